>>> rtl/bhi_pkg.sv
// ============================================================================
// bhi_pkg: shared types for the barycentric height interpolation unit
// Holds the beat structs of both channels and the datapath widths.
// ============================================================================
package bhi_pkg;

	localparam int COORD_W = 32;             // Q16.16 coordinate
	localparam int DIFF_W  = COORD_W + 1;    // coordinate difference
	localparam int PROD_W  = 2 * DIFF_W;     // difference product
	localparam int CROSS_W = PROD_W + 1;     // determinant and weight numerators
	localparam int SPLIT_W = 34;             // low slice of a numerator
	localparam int NUM_W   = CROSS_W + DIFF_W + 1; // correction numerator
	localparam int DIV_BITS = 41;            // quotient bits, saturation at 2^40
	localparam int DIVD_W  = NUM_W + 2;      // 2|N| + |D|
	localparam int DEN_W   = CROSS_W + 1;    // 2|D|
	localparam int REM_W   = DEN_W + DIV_BITS + 1;
	localparam int SUM_W   = DIV_BITS + 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_height;
		logic signed [COORD_W-1:0] first_z;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_height;
		logic signed [COORD_W-1:0] second_z;
		logic signed [COORD_W-1:0] third_x;
		logic signed [COORD_W-1:0] third_height;
		logic signed [COORD_W-1:0] third_z;
		logic signed [COORD_W-1:0] query_x;
		logic signed [COORD_W-1:0] query_z;
	} query_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] height_out;
		logic                      degenerate;
	} result_t;

endpackage

>>> rtl/barycentric_height_interp_unit.sv
// ============================================================================
// barycentric_height_interp_unit
// Interpolates a height over a triangle at a query point in fixed point.
// ============================================================================
// Usage: a query beat carries three vertices (x, height, z) and a query point
// (x, z), all signed Q16.16. One result beat comes back for every query beat:
// the interpolated height, rounded to nearest with ties away from zero and
// saturated to Q16.16, and a degenerate flag that is set, with height zero,
// when the triangle's determinant in the x/z plane is zero.
// Both channels move a beat on a rising edge with valid high and stall low.
// A new query beat is taken every cycle while no result waits under stall.
// The path runs through eight stages of differences,
// products and sums, a loading stage with the overflow test, a 41-stage
// restoring divider with one quotient bit per stage, and the output register.
// The whole pipeline advances together: while a result waits under
// result_stall, every stage holds and query_stall is raised, so no beat is
// lost or repeated. Stages that hold bubbles keep nothing of value.
// Reset clears all valid bits; no result is shown until a query flows
// through. The block keeps nothing from one query to the next.
// ============================================================================
module barycentric_height_interp_unit
	import bhi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    query_valid,
	output logic    query_stall,
	input  query_t  query,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic en;
	assign en = ~(result_valid & result_stall);
	assign query_stall = ~en;

	// Stage 1: coordinate differences.
	logic signed [DIFF_W-1:0] dx13_s1, dz23_s1, dx32_s1, dz13_s1, dz31_s1;
	logic signed [DIFF_W-1:0] dqx_s1, dqz_s1, dh13_s1, dh23_s1;
	logic signed [COORD_W-1:0] h3_s1;
	// Stage 2: products.
	logic signed [PROD_W-1:0] pd1_s2, pd2_s2, pa1_s2, pa2_s2, pb1_s2, pb2_s2;
	logic signed [DIFF_W-1:0] dh13_s2, dh23_s2;
	logic signed [COORD_W-1:0] h3_s2;
	// Stage 3: determinant and weight numerators.
	logic signed [CROSS_W-1:0] det_s3, n1_s3, n2_s3;
	logic signed [DIFF_W-1:0] dh13_s3, dh23_s3;
	logic signed [COORD_W-1:0] h3_s3;
	// Stage 4: partial products of the weighted height differences.
	logic signed [SPLIT_W+DIFF_W:0] pl1_s4, pl2_s4;
	logic signed [PROD_W-1:0] ph1_s4, ph2_s4;
	logic signed [CROSS_W-1:0] det_s4;
	logic deg_s4;
	logic signed [COORD_W-1:0] h3_s4;
	// Stage 5: recombined products.
	logic signed [NUM_W-1:0] m1_s5, m2_s5;
	logic signed [CROSS_W-1:0] det_s5;
	logic deg_s5;
	logic signed [COORD_W-1:0] h3_s5;
	// Stage 6: numerator and divisor magnitude.
	logic signed [NUM_W-1:0] num_s6;
	logic [CROSS_W-1:0] dabs_s6;
	logic dneg_s6, deg_s6;
	logic signed [COORD_W-1:0] h3_s6;
	// Stage 7: numerator magnitude and quotient sign.
	logic [NUM_W-1:0] nabs_s7;
	logic [CROSS_W-1:0] dabs_s7;
	logic neg_s7, deg_s7;
	logic signed [COORD_W-1:0] h3_s7;
	// Stage 8: rounded dividend and divisor.
	logic [DIVD_W-1:0] dvd_s8;
	logic [DEN_W-1:0] den_s8;
	logic neg_s8, deg_s8;
	logic signed [COORD_W-1:0] h3_s8;
	logic [8:1] v_s;

	// Divider stages; entry zero is loaded from stage 8 with the overflow test.
	logic [REM_W-1:0]    dv_rem_s [0:DIV_BITS];
	logic [DEN_W-1:0]    dv_den_s [0:DIV_BITS];
	logic [DIV_BITS-1:0] dv_quo_s [0:DIV_BITS];
	logic                dv_ovf_s [0:DIV_BITS];
	logic                dv_neg_s [0:DIV_BITS];
	logic                dv_deg_s [0:DIV_BITS];
	logic signed [COORD_W-1:0] dv_h3_s [0:DIV_BITS];
	logic [DIV_BITS:0]   dv_v_s;

	logic [REM_W-1:0] dv_shd [0:DIV_BITS-1];
	logic [REM_W:0]   dv_diff [0:DIV_BITS-1];

	logic [DIV_BITS-1:0]     qmag;
	logic signed [SUM_W-1:0] hsum;
	logic signed [COORD_W-1:0] hsat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s          <= '0;
			dv_v_s       <= '0;
			result_valid <= 1'b0;
		end else if (en) begin
			v_s          <= {v_s[7:1], query_valid};
			dv_v_s       <= {dv_v_s[DIV_BITS-1:0], v_s[8]};
			result_valid <= dv_v_s[DIV_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx13_s1 <= DIFF_W'(query.first_x) - DIFF_W'(query.third_x);
			dz23_s1 <= DIFF_W'(query.second_z) - DIFF_W'(query.third_z);
			dx32_s1 <= DIFF_W'(query.third_x) - DIFF_W'(query.second_x);
			dz13_s1 <= DIFF_W'(query.first_z) - DIFF_W'(query.third_z);
			dz31_s1 <= DIFF_W'(query.third_z) - DIFF_W'(query.first_z);
			dqx_s1  <= DIFF_W'(query.query_x) - DIFF_W'(query.third_x);
			dqz_s1  <= DIFF_W'(query.query_z) - DIFF_W'(query.third_z);
			dh13_s1 <= DIFF_W'(query.first_height) - DIFF_W'(query.third_height);
			dh23_s1 <= DIFF_W'(query.second_height) - DIFF_W'(query.third_height);
			h3_s1   <= query.third_height;

			pd1_s2  <= PROD_W'(dz23_s1) * PROD_W'(dx13_s1);
			pd2_s2  <= PROD_W'(dx32_s1) * PROD_W'(dz13_s1);
			pa1_s2  <= PROD_W'(dz23_s1) * PROD_W'(dqx_s1);
			pa2_s2  <= PROD_W'(dx32_s1) * PROD_W'(dqz_s1);
			pb1_s2  <= PROD_W'(dz31_s1) * PROD_W'(dqx_s1);
			pb2_s2  <= PROD_W'(dx13_s1) * PROD_W'(dqz_s1);
			dh13_s2 <= dh13_s1;
			dh23_s2 <= dh23_s1;
			h3_s2   <= h3_s1;

			det_s3  <= CROSS_W'(pd1_s2) + CROSS_W'(pd2_s2);
			n1_s3   <= CROSS_W'(pa1_s2) + CROSS_W'(pa2_s2);
			n2_s3   <= CROSS_W'(pb1_s2) + CROSS_W'(pb2_s2);
			dh13_s3 <= dh13_s2;
			dh23_s3 <= dh23_s2;
			h3_s3   <= h3_s2;

			// Each numerator is split into an unsigned low slice and a signed
			// high slice so that no multiplier is much wider than 33 bits.
			pl1_s4 <= (SPLIT_W+DIFF_W+1)'($signed({1'b0, n1_s3[SPLIT_W-1:0]}))
				* (SPLIT_W+DIFF_W+1)'(dh13_s3);
			pl2_s4 <= (SPLIT_W+DIFF_W+1)'($signed({1'b0, n2_s3[SPLIT_W-1:0]}))
				* (SPLIT_W+DIFF_W+1)'(dh23_s3);
			ph1_s4 <= PROD_W'($signed(n1_s3[CROSS_W-1:SPLIT_W])) * PROD_W'(dh13_s3);
			ph2_s4 <= PROD_W'($signed(n2_s3[CROSS_W-1:SPLIT_W])) * PROD_W'(dh23_s3);
			det_s4 <= det_s3;
			deg_s4 <= (det_s3 == '0);
			h3_s4  <= h3_s3;

			m1_s5  <= (NUM_W'(ph1_s4) <<< SPLIT_W) + NUM_W'(pl1_s4);
			m2_s5  <= (NUM_W'(ph2_s4) <<< SPLIT_W) + NUM_W'(pl2_s4);
			det_s5 <= det_s4;
			deg_s5 <= deg_s4;
			h3_s5  <= h3_s4;

			num_s6  <= m1_s5 + m2_s5;
			dabs_s6 <= det_s5[CROSS_W-1] ? CROSS_W'(-det_s5) : CROSS_W'(det_s5);
			dneg_s6 <= det_s5[CROSS_W-1];
			deg_s6  <= deg_s5;
			h3_s6   <= h3_s5;

			nabs_s7 <= num_s6[NUM_W-1] ? NUM_W'(-num_s6) : NUM_W'(num_s6);
			neg_s7  <= num_s6[NUM_W-1] ^ dneg_s6;
			dabs_s7 <= dabs_s6;
			deg_s7  <= deg_s6;
			h3_s7   <= h3_s6;

			// Rounding to nearest: floor((2|N| + |D|) / (2|D|)).
			dvd_s8 <= DIVD_W'({nabs_s7, 1'b0}) + DIVD_W'(dabs_s7);
			den_s8 <= {dabs_s7, 1'b0};
			neg_s8 <= neg_s7;
			deg_s8 <= deg_s7;
			h3_s8  <= h3_s7;

			dv_rem_s[0] <= REM_W'(dvd_s8);
			dv_den_s[0] <= den_s8;
			dv_quo_s[0] <= '0;
			dv_ovf_s[0] <= REM_W'(dvd_s8) >= (REM_W'(den_s8) << DIV_BITS);
			dv_neg_s[0] <= neg_s8;
			dv_deg_s[0] <= deg_s8;
			dv_h3_s[0]  <= h3_s8;

			for (int k = 0; k < DIV_BITS; k++) begin
				dv_rem_s[k+1] <= dv_diff[k][REM_W] ? dv_rem_s[k] : dv_diff[k][REM_W-1:0];
				dv_quo_s[k+1] <= {dv_quo_s[k][DIV_BITS-2:0], ~dv_diff[k][REM_W]};
				dv_den_s[k+1] <= dv_den_s[k];
				dv_ovf_s[k+1] <= dv_ovf_s[k];
				dv_neg_s[k+1] <= dv_neg_s[k];
				dv_deg_s[k+1] <= dv_deg_s[k];
				dv_h3_s[k+1]  <= dv_h3_s[k];
			end

			result.height_out <= dv_deg_s[DIV_BITS] ? '0 : hsat;
			result.degenerate <= dv_deg_s[DIV_BITS];
		end
	end

	// Stage k tries the divisor shifted to quotient bit DIV_BITS-1-k.
	always_comb begin
		for (int k = 0; k < DIV_BITS; k++) begin
			dv_shd[k]  = REM_W'(dv_den_s[k]) << (DIV_BITS - 1 - k);
			dv_diff[k] = {1'b0, dv_rem_s[k]} - {1'b0, dv_shd[k]};
		end
	end

	always_comb begin
		qmag = dv_ovf_s[DIV_BITS] ? {1'b1, {(DIV_BITS-1){1'b0}}} : dv_quo_s[DIV_BITS];
		hsum = SUM_W'(dv_h3_s[DIV_BITS])
			+ (dv_neg_s[DIV_BITS] ? -$signed(SUM_W'(qmag)) : $signed(SUM_W'(qmag)));
		if (hsum > SUM_W'(32'sh7fff_ffff))
			hsat = 32'sh7fff_ffff;
		else if (hsum < SUM_W'(32'sh8000_0000))
			hsat = 32'sh8000_0000;
		else
			hsat = hsum[COORD_W-1:0];
	end

endmodule

>>> test/tb_barycentric_height_interp_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the barycentric height interpolation unit
// Drives query beats with random gaps and result stalls, predicts each height
// with exact wide integer arithmetic and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_barycentric_height_interp_unit;
	import bhi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	class height_scoreboard;
		result_t pending[$];
		int      errors = 0;

		// Exact interpolation: h3 + round((n1*(h1-h3) + n2*(h2-h3)) / det), saturated.
		function result_t interpolate(query_t q);
			result_t r;
			logic signed [255:0] x1, h1, z1, x2, h2, z2, x3, h3, z3, qx, qz;
			logic signed [255:0] det, n1, n2, num, nmag, dmag, quo, sum;
			logic neg;
			x1 = q.first_x;  h1 = q.first_height;  z1 = q.first_z;
			x2 = q.second_x; h2 = q.second_height; z2 = q.second_z;
			x3 = q.third_x;  h3 = q.third_height;  z3 = q.third_z;
			qx = q.query_x;  qz = q.query_z;
			det = (z2 - z3) * (x1 - x3) + (x3 - x2) * (z1 - z3);
			r.degenerate = (det == 0);
			r.height_out = '0;
			if (det != 0) begin
				n1 = (z2 - z3) * (qx - x3) + (x3 - x2) * (qz - z3);
				n2 = (z3 - z1) * (qx - x3) + (x1 - x3) * (qz - z3);
				num = n1 * (h1 - h3) + n2 * (h2 - h3);
				neg = (num < 0) != (det < 0);
				nmag = (num < 0) ? -num : num;
				dmag = (det < 0) ? -det : det;
				quo = (2 * nmag + dmag) / (2 * dmag);
				if (quo > (256'sd1 <<< 40))
					quo = 256'sd1 <<< 40;
				sum = h3 + (neg ? -quo : quo);
				if (sum > 256'sd2147483647)
					sum = 256'sd2147483647;
				if (sum < -256'sd2147483648)
					sum = -256'sd2147483648;
				r.height_out = sum[31:0];
			end
			return r;
		endfunction

		function void note_query(query_t q);
			pending.push_back(interpolate(q));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("result beat with no query outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.height_out !== want.height_out) begin
				$error("height_out expected %0d got %0d", want.height_out, got.height_out);
				errors++;
			end
			if (got.degenerate !== want.degenerate) begin
				$error("degenerate expected %0b got %0b", want.degenerate, got.degenerate);
				errors++;
			end
		endfunction
	endclass

	localparam int LATENCY   = 51;
	localparam int N_RANDOM  = 1250;
	localparam int MAX_CYCLE = 400000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    query_valid = 1'b0;
	logic    query_stall;
	query_t  query = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	height_scoreboard sb = new();
	int  cycle = 0;
	int  sink_mode = 0;  // 0 random stalls, 1 none, 2 long hold-off

	barycentric_height_interp_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.query        (query),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLE) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: check accepted beats and choose the stall for the next edge.
	int hold_left = 0;
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (sink_mode == 2) begin
			hold_left <= 200;
			sink_mode = 0;
			result_stall <= 1'b1;
		end else if (sink_mode == 1) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < 25);
		end
	end

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(65535) << $urandom_range(16);
			3: return -($urandom_range(65535) << $urandom_range(16));
			default: return $urandom;
		endcase
	endfunction

	// One beat; gap chance in percent. Holds payload until accepted, and
	// leaves valid high so that the next beat can follow without a gap.
	task automatic send(query_t q, int gap_pct);
		while ($urandom_range(99) < gap_pct) begin
			query_valid <= 1'b0;
			@(posedge clk);
		end
		query_valid <= 1'b1;
		query <= q;
		@(posedge clk);
		while (query_stall)
			@(posedge clk);
		sb.note_query(q);
	endtask

	task automatic drain();
		query_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic query_t random_query();
		query_t q;
		q = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
			pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
			pick_coord()};
		// Some triangles collapse on purpose so the degenerate path is hit.
		if ($urandom_range(19) == 0) begin
			q.second_x = q.first_x;
			q.second_z = q.first_z;
		end
		return q;
	endfunction

	initial begin
		query_t q;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats: a plain triangle, queries on an edge and far outside,
		// collapsed triangles and the coordinate extremes.
		q = '0;
		q.second_x = 32'h0001_0000; q.third_z = 32'h0001_0000;
		q.first_height = 32'h0002_0000; q.second_height = 32'h0004_0000;
		q.third_height = 32'h0008_0000;
		q.query_x = 32'h0000_4000; q.query_z = 32'h0000_4000;
		send(q, 0);
		q.query_x = 32'h0000_8000; q.query_z = 32'h0000_0000;
		send(q, 0);
		q.query_x = 32'h7fff_ffff; q.query_z = 32'h7fff_ffff;
		send(q, 0);
		q.query_x = 32'h8000_0000; q.query_z = 32'h8000_0000;
		send(q, 0);
		q.first_height = 32'h7fff_ffff; q.second_height = 32'h8000_0000;
		q.third_height = 32'h7fff_ffff;
		send(q, 0);
		q = '0;
		send(q, 0);
		q = '1;
		send(q, 0);
		q = {11{32'h8000_0000}};
		send(q, 0);
		q = {11{32'h7fff_ffff}};
		send(q, 0);
		q = {32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000};
		send(q, 0);
		q = {32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1,
			32'h1, 32'h1};
		send(q, 0);
		for (int i = 0; i < 6; i++)
			send(random_query(), 0);

		// Random traffic with gaps and stalls.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 300)
				sink_mode = 2;  // receiver holds off while the sender keeps going
			if (i == 600) begin
				drain();
				sink_mode = 1;
			end
			if (i == 900)
				sink_mode = 0;
			send(random_query(), (i >= 600 && i < 900) ? 0 : 25);
		end

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
